### design/hcp_pkg.sv
// hcp_pkg: shared widths, codes and defaults for the hot code promotion table
// used by hcp_front, hcp_back and the top level; no dependencies

package hcp_pkg;

  localparam int ADDR_W          = 48;
  localparam int HITS_W          = 16;
  localparam int COUNT_W         = 32;
  localparam int THRESH_W        = 16;
  localparam int MODE_W          = 2;
  localparam int ROUTE_W         = 2;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 16;
  localparam int HASH_SHIFT      = 4;
  localparam int TABLE_SLOTS_DEF = 256;
  localparam int ENTRY_W         = ADDR_W + HITS_W + 1;

  localparam logic [HITS_W-1:0] HITS_MAX = '1;

  localparam logic [MODE_W-1:0] MODE_INTERP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NATIVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd2;

  localparam logic [ROUTE_W-1:0] ROUTE_INTERP  = 2'd0;
  localparam logic [ROUTE_W-1:0] ROUTE_COMPILE = 2'd1;
  localparam logic [ROUTE_W-1:0] ROUTE_NATIVE  = 2'd2;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_EXEC_MODE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_THRESHOLD = 1'd1;

  localparam logic [MODE_W-1:0]   EXEC_MODE_RST     = MODE_AUTO;
  localparam logic [THRESH_W-1:0] HOT_THRESHOLD_RST = 16'd100;

endpackage

### design/hcp_ram.sv
// hcp_ram: generic single write port, single read port ram with registered read
// no dependencies

module hcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;
  logic [AW-1:0]    rsel;

  assign rsel  = raddr;
  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[rsel];
    end
  end

endmodule

### design/hcp_queue.sv
// hcp_queue: two entry fifo between the classify front and the probe back
// no dependencies

module hcp_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             push, pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### design/hcp_front.sv
// hcp_front: accepts items, flags address zero and computes the home slot
// depends on hcp_pkg

module hcp_front #(
  parameter int TABLE_SLOTS = hcp_pkg::TABLE_SLOTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  clearing,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [hcp_pkg::ADDR_W-1:0]            in_block_address,
  output logic                                  q_valid,
  input  logic                                  q_ready,
  output logic [hcp_pkg::ADDR_W+$clog2(TABLE_SLOTS):0] q_data
);

  import hcp_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_SLOTS);
  localparam bit POW2    = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
  localparam int KEY_W   = ADDR_W - HASH_SHIFT;
  localparam int CHUNK_W = (KEY_W + 3) / 4;
  localparam int KEY_PAD = 4 * CHUNK_W;
  localparam int SUM_W   = CHUNK_W + IDX_W + 2;
  localparam longint SLOTS_L = longint'(TABLE_SLOTS);
  localparam logic [SUM_W-1:0] SLOTS_V = SUM_W'(SLOTS_L);
  localparam logic [SUM_W-1:0] RECIP   = SUM_W'((longint'(1) << SUM_W) / SLOTS_L);
  localparam logic [SUM_W-1:0] FOLD1   = SUM_W'((longint'(1) << CHUNK_W) % SLOTS_L);
  localparam logic [SUM_W-1:0] FOLD2   = SUM_W'((longint'(1) << (2 * CHUNK_W)) % SLOTS_L);
  localparam logic [SUM_W-1:0] FOLD3   = SUM_W'((longint'(1) << (3 * CHUNK_W)) % SLOTS_L);
  localparam logic [1:0] STEP_FOLD = 2'd3;
  localparam logic [1:0] STEP_DIV  = 2'd2;

  logic               stg_valid_r, stg_valid_nxt;
  logic [ADDR_W-1:0]  stg_addr_r, stg_addr_nxt;
  logic [SUM_W-1:0]   stg_sum_r, stg_sum_nxt;
  logic [SUM_W-1:0]   stg_quo_r, stg_quo_nxt;
  logic [IDX_W-1:0]   stg_rem_r, stg_rem_nxt;
  logic [1:0]         stg_cnt_r, stg_cnt_nxt;
  logic [KEY_PAD-1:0] key;
  logic [SUM_W-1:0]   fold_sum;
  logic [2*SUM_W-1:0] quo_prod;
  logic [SUM_W-1:0]   rem_raw, rem_fix;
  logic [IDX_W-1:0]   home;
  logic               addr_zero;
  logic               accept, push;

  // remainder mod slot count: fold by chunk residues, reciprocal multiply, one fixup
  assign key      = KEY_PAD'(stg_addr_r[ADDR_W-1:HASH_SHIFT]);
  assign fold_sum = SUM_W'(key[0 +: CHUNK_W])
                  + SUM_W'(key[CHUNK_W +: CHUNK_W]) * FOLD1
                  + SUM_W'(key[2*CHUNK_W +: CHUNK_W]) * FOLD2
                  + SUM_W'(key[3*CHUNK_W +: CHUNK_W]) * FOLD3;
  assign quo_prod = {{SUM_W{1'b0}}, stg_sum_r} * {{SUM_W{1'b0}}, RECIP};
  assign rem_raw  = stg_sum_r - SUM_W'(stg_quo_r * SLOTS_V);
  assign rem_fix  = (rem_raw >= SLOTS_V) ? rem_raw - SLOTS_V : rem_raw;

  assign addr_zero = (stg_addr_r == '0);
  assign home      = POW2 ? stg_addr_r[HASH_SHIFT +: IDX_W] : stg_rem_r;

  assign q_valid  = stg_valid_r && (stg_cnt_r == '0);
  assign q_data   = {addr_zero, home, stg_addr_r};
  assign push     = q_valid && q_ready;
  assign in_ready = !clearing && (!stg_valid_r || push);
  assign accept   = in_valid && in_ready;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    stg_addr_nxt  = stg_addr_r;
    stg_sum_nxt   = stg_sum_r;
    stg_quo_nxt   = stg_quo_r;
    stg_rem_nxt   = stg_rem_r;
    stg_cnt_nxt   = stg_cnt_r;
    if (stg_valid_r && (stg_cnt_r != '0)) begin
      stg_cnt_nxt = stg_cnt_r - 1'b1;
      unique case (stg_cnt_r)
        STEP_FOLD: stg_sum_nxt = fold_sum;
        STEP_DIV:  stg_quo_nxt = quo_prod[2*SUM_W-1:SUM_W];
        default:   stg_rem_nxt = rem_fix[IDX_W-1:0];
      endcase
    end
    if (push) begin
      stg_valid_nxt = 1'b0;
    end
    if (accept) begin
      stg_valid_nxt = 1'b1;
      stg_addr_nxt  = in_block_address;
      stg_rem_nxt   = '0;
      stg_cnt_nxt   = (POW2 || (in_block_address == '0)) ? '0 : STEP_FOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      stg_cnt_r   <= '0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      stg_cnt_r   <= stg_cnt_nxt;
    end
    stg_addr_r <= stg_addr_nxt;
    stg_sum_r  <= stg_sum_nxt;
    stg_quo_r  <= stg_quo_nxt;
    stg_rem_r  <= stg_rem_nxt;
  end

endmodule

### design/hcp_back.sv
// hcp_back: clears the slot table, probes it linearly, updates hit counts
// and routes, keeps running totals; depends on hcp_pkg and hcp_ram

module hcp_back #(
  parameter int TABLE_SLOTS = hcp_pkg::TABLE_SLOTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [hcp_pkg::MODE_W-1:0]            exec_mode,
  input  logic [hcp_pkg::THRESH_W-1:0]          hot_threshold,
  output logic                                  clearing,
  input  logic                                  q_valid,
  output logic                                  q_ready,
  input  logic [hcp_pkg::ADDR_W+$clog2(TABLE_SLOTS):0] q_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_status,
  output logic [hcp_pkg::ROUTE_W-1:0]           out_route,
  output logic                                  out_table_full,
  output logic [hcp_pkg::COUNT_W-1:0]           out_total_dispatches,
  output logic [hcp_pkg::COUNT_W-1:0]           out_interp_dispatches,
  output logic [hcp_pkg::COUNT_W-1:0]           out_native_dispatches
);

  import hcp_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_PROBE} state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   probe_r, probe_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic [COUNT_W-1:0] interp_r, interp_nxt;
  logic [COUNT_W-1:0] native_r, native_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_status_r, out_status_nxt;
  logic [ROUTE_W-1:0] out_route_r, out_route_nxt;
  logic               out_full_r, out_full_nxt;

  logic               q_zero;
  logic [IDX_W-1:0]   q_home;
  logic [ADDR_W-1:0]  q_addr;
  logic               out_free;

  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic [ADDR_W-1:0]  rd_tag;
  logic [HITS_W-1:0]  rd_hits;
  logic               rd_comp;
  logic               slot_empty, slot_hit;
  logic [HITS_W-1:0]  base_hits, hits_inc, new_hits;
  logic               base_comp, native;
  logic [ROUTE_W-1:0] route;

  hcp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign {q_zero, q_home, q_addr}   = q_data;
  assign {rd_tag, rd_hits, rd_comp} = ram_rdata;
  assign out_free = !out_valid_r || out_ready;
  assign clearing = (state_r == ST_CLEAR);

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_route             = out_route_r;
  assign out_table_full        = out_full_r;
  assign out_total_dispatches  = total_r;
  assign out_interp_dispatches = interp_r;
  assign out_native_dispatches = native_r;

  // slot update for a found or freshly inserted address
  always_comb begin
    slot_empty = (rd_tag == '0);
    slot_hit   = (rd_tag == addr_r);
    base_hits  = slot_empty ? '0 : rd_hits;
    base_comp  = slot_empty ? 1'b0 : rd_comp;
    hits_inc   = (base_hits == HITS_MAX) ? base_hits : base_hits + 1'b1;
    unique case (exec_mode)
      MODE_NATIVE: begin
        native   = 1'b1;
        new_hits = base_hits;
      end
      MODE_AUTO: begin
        native   = (hits_inc >= hot_threshold);
        new_hits = hits_inc;
      end
      default: begin
        native   = 1'b0;
        new_hits = base_hits;
      end
    endcase
    route = native ? (base_comp ? ROUTE_NATIVE : ROUTE_COMPILE) : ROUTE_INTERP;
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    probe_nxt      = probe_r;
    addr_nxt       = addr_r;
    total_nxt      = total_r;
    interp_nxt     = interp_r;
    native_nxt     = native_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_route_nxt  = out_route_r;
    out_full_nxt   = out_full_r;
    q_ready        = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = idx_r;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_ready = 1'b1;
          if (q_zero) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_REJECT;
            out_route_nxt  = ROUTE_INTERP;
            out_full_nxt   = 1'b0;
          end else begin
            addr_nxt  = q_addr;
            idx_nxt   = q_home;
            probe_nxt = '0;
            ram_re    = 1'b1;
            ram_raddr = q_home;
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (slot_empty || slot_hit) begin
          ram_we         = 1'b1;
          ram_wdata      = {addr_r, new_hits, base_comp | native};
          total_nxt      = total_r + 1'b1;
          native_nxt     = native ? native_r + 1'b1 : native_r;
          interp_nxt     = native ? interp_r : interp_r + 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_OK;
          out_route_nxt  = route;
          out_full_nxt   = 1'b0;
          state_nxt      = ST_IDLE;
        end else if (probe_r == LAST_IDX) begin
          total_nxt      = total_r + 1'b1;
          interp_nxt     = interp_r + 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_OK;
          out_route_nxt  = ROUTE_INTERP;
          out_full_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          idx_nxt   = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
          probe_nxt = probe_r + 1'b1;
          ram_re    = 1'b1;
          ram_raddr = idx_nxt;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      total_r     <= '0;
      interp_r    <= '0;
      native_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      total_r     <= total_nxt;
      interp_r    <= interp_nxt;
      native_r    <= native_nxt;
      out_valid_r <= out_valid_nxt;
    end
    probe_r      <= probe_nxt;
    addr_r       <= addr_nxt;
    out_status_r <= out_status_nxt;
    out_route_r  <= out_route_nxt;
    out_full_r   <= out_full_nxt;
  end

endmodule

### design/hot_code_promotion_table.sv
// hot_code_promotion_table: top level with config registers, front, queue, back
// depends on hcp_pkg, hcp_front, hcp_queue, hcp_back
// path: the front registers each item and, for a non-power-of-two slot count, finds the
// home slot in fold, divide and fixup steps; the queue buffers it; the back issues the
// first table read, then one read per slot probed, and takes one item at a time over the
// single table read port; the front takes a new item only as it hands on the last one
// reset: a clearing pass writes every slot empty in turn; in_ready
// stays low meanwhile, config writes are taken as usual

module hot_code_promotion_table #(
  parameter int TABLE_SLOTS = hcp_pkg::TABLE_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [hcp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hcp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [hcp_pkg::ADDR_W-1:0]         in_block_address,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_status,
  output logic [hcp_pkg::ROUTE_W-1:0]        out_route,
  output logic                               out_table_full,
  output logic [hcp_pkg::COUNT_W-1:0]        out_total_dispatches,
  output logic [hcp_pkg::COUNT_W-1:0]        out_interp_dispatches,
  output logic [hcp_pkg::COUNT_W-1:0]        out_native_dispatches
);

  import hcp_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int Q_W   = ADDR_W + IDX_W + 1;

  logic [MODE_W-1:0]   exec_mode_r, exec_mode_nxt;
  logic [THRESH_W-1:0] hot_threshold_r, hot_threshold_nxt;
  logic                clearing;
  logic                fq_valid, fq_ready;
  logic [Q_W-1:0]      fq_data;
  logic                qb_valid, qb_ready;
  logic [Q_W-1:0]      qb_data;

  always_comb begin
    exec_mode_nxt     = exec_mode_r;
    hot_threshold_nxt = hot_threshold_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXEC_MODE:     exec_mode_nxt     = cfg_wdata[MODE_W-1:0];
        CFG_HOT_THRESHOLD: hot_threshold_nxt = cfg_wdata[THRESH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exec_mode_r     <= EXEC_MODE_RST;
      hot_threshold_r <= HOT_THRESHOLD_RST;
    end else begin
      exec_mode_r     <= exec_mode_nxt;
      hot_threshold_r <= hot_threshold_nxt;
    end
  end

  hcp_front #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .clearing         (clearing),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_block_address (in_block_address),
    .q_valid          (fq_valid),
    .q_ready          (fq_ready),
    .q_data           (fq_data)
  );

  hcp_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  hcp_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .exec_mode             (exec_mode_r),
    .hot_threshold         (hot_threshold_r),
    .clearing              (clearing),
    .q_valid               (qb_valid),
    .q_ready               (qb_ready),
    .q_data                (qb_data),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_route             (out_route),
    .out_table_full        (out_table_full),
    .out_total_dispatches  (out_total_dispatches),
    .out_interp_dispatches (out_interp_dispatches),
    .out_native_dispatches (out_native_dispatches)
  );

  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) clearing |-> !in_ready
  ) else $error("item accepted during table clearing pass");

  a_totals_consistent: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_total_dispatches ==
                   COUNT_W'(out_interp_dispatches + out_native_dispatches))
  ) else $error("dispatch totals disagree");

  a_full_interprets: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |->
      (out_route == ROUTE_INTERP && out_status == STATUS_OK)
  ) else $error("full table result not routed to interpreter");

  a_reject_clean: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_REJECT) |->
      (out_route == ROUTE_INTERP && !out_table_full)
  ) else $error("rejected item carries route or full flag");

endmodule
